// File: design/trm_pkg.sv
// Package for the ternary rule match list unit.
// Holds payload structs, controller state and command/status types, shared constants.
// No dependencies.
package trm_pkg;

    localparam int FIELD_BITS = 16;
    localparam int IDX_W      = 6;
    localparam int SPEC_W     = 5;
    localparam int COUNT_W    = 7;
    localparam int POS_W      = 5;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int RULE_W     = 2 * FIELD_BITS + SPEC_W;

    localparam int POSITIONS_DEFAULT = 16;
    localparam int ENTRIES_DEFAULT   = 64;

    localparam logic [POS_W-1:0]   POSITIONS_RESET = POS_W'(16);
    localparam logic [COUNT_W-1:0] ENTRIES_RESET   = '0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POSITIONS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 1'b1;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_MATCH = 1'b1;

    typedef struct packed {
        logic                  req_type;
        logic [IDX_W-1:0]      entry_index;
        logic [FIELD_BITS-1:0] care_bits;
        logic [FIELD_BITS-1:0] value_bits;
        logic [FIELD_BITS-1:0] message_bits;
    } req_t;

    typedef struct packed {
        logic               matched;
        logic [IDX_W-1:0]   match_index;
        logic [SPEC_W-1:0]  specificity;
        logic [COUNT_W-1:0] match_count;
        logic               last;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PRIME,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic load_commit;
        logic prime;
        logic scan_step;
        logic finish;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_match;
        logic scan_empty;
        logic out_free;
        logic hit;
        logic pend_valid;
        logic last_entry;
    } stat_t;

endpackage

// File: design/trm_ram.sv
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
module trm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/trm_ctrl.sv
// Sequencer for the ternary rule match list unit: load, scan and flush steps.
// Depends on trm_pkg.
module trm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  trm_pkg::stat_t stat,
    output trm_pkg::cmd_t  cmd
);

    trm_pkg::state_t state_reg;
    trm_pkg::state_t state_next;
    logic            advance;

    // A hit with a result already pending needs the output slot.
    assign advance = !(stat.hit && stat.pend_valid) || stat.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trm_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            trm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = trm_pkg::ST_LOAD;
                end
            end
            trm_pkg::ST_LOAD:
            begin
                if (stat.is_match)
                begin
                    state_next = trm_pkg::ST_PRIME;
                end
                else if (stat.out_free)
                begin
                    state_next = trm_pkg::ST_IDLE;
                end
            end
            trm_pkg::ST_PRIME:
            begin
                state_next = stat.scan_empty ? trm_pkg::ST_FINISH : trm_pkg::ST_SCAN;
            end
            trm_pkg::ST_SCAN:
            begin
                if (advance && stat.last_entry)
                begin
                    state_next = trm_pkg::ST_FINISH;
                end
            end
            trm_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = trm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = trm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall       = 1'b1;
        cmd.capture     = 1'b0;
        cmd.load_commit = 1'b0;
        cmd.prime       = 1'b0;
        cmd.scan_step   = 1'b0;
        cmd.finish      = 1'b0;
        case (state_reg)
            trm_pkg::ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            trm_pkg::ST_LOAD:
            begin
                cmd.load_commit = !stat.is_match && stat.out_free;
            end
            trm_pkg::ST_PRIME:
            begin
                cmd.prime = 1'b1;
            end
            trm_pkg::ST_SCAN:
            begin
                cmd.scan_step = advance;
            end
            trm_pkg::ST_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: design/trm_dp.sv
// Datapath for the ternary rule match list unit: config registers, captured item,
// rule RAM, scan counter, pending result and output register.
// Depends on trm_pkg and trm_ram.
module trm_dp #(
    parameter int POSITIONS = trm_pkg::POSITIONS_DEFAULT,
    parameter int ENTRIES   = trm_pkg::ENTRIES_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [trm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [trm_pkg::CFG_W-1:0]        cfg_wdata,
    input  trm_pkg::req_t                    req,
    input  trm_pkg::cmd_t                    cmd,
    output trm_pkg::stat_t                   stat,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output trm_pkg::rsp_t                    rsp
);

    localparam int AW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int FB   = trm_pkg::FIELD_BITS;
    localparam int PLIM = (POSITIONS < FB) ? POSITIONS : FB;
    localparam int SW   = trm_pkg::SPEC_W;
    localparam int NCW  = trm_pkg::COUNT_W;
    localparam int NSLOT = 1 << trm_pkg::IDX_W;

    // Config registers
    logic [trm_pkg::POS_W-1:0] pos_reg;
    logic [NCW-1:0]            ent_reg;

    // Captured item
    logic          cap_type_reg;
    logic [AW-1:0] cap_slot_reg;
    logic [FB-1:0] cap_care_reg;
    logic [FB-1:0] cap_value_reg;
    logic [FB-1:0] cap_msg_reg;

    // Scan state
    logic [CW-1:0]  idx_reg;
    logic [NCW-1:0] count_reg;
    logic           pend_valid_reg;
    logic [AW-1:0]  pend_idx_reg;
    logic [SW-1:0]  pend_spec_reg;

    // Output register
    logic          rsp_valid_reg;
    logic          rsp_valid_next;
    trm_pkg::rsp_t rsp_reg;
    trm_pkg::rsp_t rsp_next;
    logic          push;

    logic [AW-1:0]              slot_tab [NSLOT];
    logic [trm_pkg::POS_W-1:0]  plim;
    logic [FB-1:0]              pmask;
    logic [CW-1:0]              n_eff;
    logic [CW-1:0]              idx_inc;
    logic [SW-1:0]              spec_load;
    logic [3:0]                 ones_lo;
    logic [3:0]                 ones_hi;
    logic [FB-1:0]              care_masked;
    logic                       out_free;

    // RAM word: {care, value, specificity}
    logic [trm_pkg::RULE_W-1:0] ram_rdata;
    logic [FB-1:0]              rd_care;
    logic [FB-1:0]              rd_value;
    logic [SW-1:0]              rd_spec;
    logic                       ram_re;
    logic [AW-1:0]              ram_raddr;
    logic                       hit;

    // Slot wrap table, folded at elaboration
    for (genvar g = 0; g < NSLOT; g++)
    begin : g_slot
        assign slot_tab[g] = AW'(g % ENTRIES);
    end

    assign plim = (pos_reg > trm_pkg::POS_W'(PLIM)) ? trm_pkg::POS_W'(PLIM) : pos_reg;

    always_comb
    begin
        for (int j = 0; j < FB; j++)
        begin
            pmask[j] = (trm_pkg::POS_W'(j) < plim);
        end
    end

    assign n_eff   = (ent_reg > NCW'(ENTRIES)) ? CW'(ENTRIES) : ent_reg[CW-1:0];
    assign idx_inc = idx_reg + CW'(1);

    // Specificity of the captured care bits, two byte counts then one add
    assign care_masked = cap_care_reg & pmask;
    always_comb
    begin
        ones_lo = '0;
        ones_hi = '0;
        for (int j = 0; j < FB / 2; j++)
        begin
            ones_lo = ones_lo + 4'(care_masked[j]);
            ones_hi = ones_hi + 4'(care_masked[j + FB / 2]);
        end
    end
    assign spec_load = SW'(ones_lo) + SW'(ones_hi);

    assign rd_care  = ram_rdata[trm_pkg::RULE_W-1 -: FB];
    assign rd_value = ram_rdata[SW + FB - 1 -: FB];
    assign rd_spec  = ram_rdata[SW-1:0];
    assign hit      = (((cap_msg_reg ^ rd_value) & rd_care & pmask) == '0);

    assign ram_re    = cmd.prime || (cmd.scan_step && (idx_inc != n_eff));
    assign ram_raddr = cmd.prime ? '0 : idx_inc[AW-1:0];

    trm_ram #(
        .WIDTH (trm_pkg::RULE_W),
        .DEPTH (ENTRIES)
    ) u_rules (
        .clk   (clk),
        .we    (cmd.load_commit),
        .waddr (cap_slot_reg),
        .wdata ({cap_care_reg, cap_value_reg, spec_load}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        push     = 1'b0;
        rsp_next = rsp_reg;
        if (cmd.load_commit)
        begin
            push                 = 1'b1;
            rsp_next.matched     = 1'b0;
            rsp_next.match_index = trm_pkg::IDX_W'(cap_slot_reg);
            rsp_next.specificity = spec_load;
            rsp_next.match_count = '0;
            rsp_next.last        = 1'b1;
        end
        else if (cmd.scan_step && hit && pend_valid_reg)
        begin
            push                 = 1'b1;
            rsp_next.matched     = 1'b1;
            rsp_next.match_index = trm_pkg::IDX_W'(pend_idx_reg);
            rsp_next.specificity = pend_spec_reg;
            rsp_next.match_count = count_reg;
            rsp_next.last        = 1'b0;
        end
        else if (cmd.finish)
        begin
            push = 1'b1;
            if (pend_valid_reg)
            begin
                rsp_next.matched     = 1'b1;
                rsp_next.match_index = trm_pkg::IDX_W'(pend_idx_reg);
                rsp_next.specificity = pend_spec_reg;
                rsp_next.match_count = count_reg;
            end
            else
            begin
                rsp_next.matched     = 1'b0;
                rsp_next.match_index = '0;
                rsp_next.specificity = '0;
                rsp_next.match_count = '0;
            end
            rsp_next.last = 1'b1;
        end
    end

    assign rsp_valid_next = push || (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= trm_pkg::POSITIONS_RESET;
            ent_reg        <= trm_pkg::ENTRIES_RESET;
            rsp_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    trm_pkg::CFG_POSITIONS: pos_reg <= cfg_wdata[trm_pkg::POS_W-1:0];
                    trm_pkg::CFG_ENTRIES:   ent_reg <= cfg_wdata[NCW-1:0];
                    default:                pos_reg <= pos_reg;
                endcase
            end
            rsp_valid_reg <= rsp_valid_next;
            if (cmd.capture)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step && hit)
            begin
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cap_type_reg  <= req.req_type;
            cap_slot_reg  <= slot_tab[req.entry_index];
            cap_care_reg  <= req.care_bits;
            cap_value_reg <= req.value_bits;
            cap_msg_reg   <= req.message_bits;
            count_reg     <= '0;
        end
        else if (cmd.scan_step && hit)
        begin
            count_reg     <= count_reg + NCW'(1);
            pend_idx_reg  <= idx_reg[AW-1:0];
            pend_spec_reg <= rd_spec;
        end
        if (cmd.prime)
        begin
            idx_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_inc;
        end
        if (push)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign stat.is_match   = (cap_type_reg == trm_pkg::REQ_MATCH);
    assign stat.scan_empty = (n_eff == '0);
    assign stat.out_free   = out_free;
    assign stat.hit        = hit;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.last_entry = (idx_inc == n_eff);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: design/ternary_rule_match_list_unit.sv
// Ternary rule match list unit: top level, controller plus datapath.
// Depends on trm_pkg, trm_ctrl, trm_dp (which holds trm_ram).
//
// Usage:
//   req channel (req_valid / req_stall / req) takes one beat per item. A load beat
//   (req_type 0) writes one rule slot and returns one acknowledge beat. A match beat
//   (req_type 1) scans entries 0 .. entries_in_use-1 and returns one beat per hit in
//   ascending index order, the final one with last set; with no hit a single beat
//   with matched clear and last set comes back.
//   rsp channel (rsp_valid / rsp_stall / rsp) is driven from an output register.
//   cfg port: cfg_wr_en with cfg_index 0 sets positions_in_use, 1 sets
//   entries_in_use; write only while the unit is idle.
// Flow:
//   One item is in flight at a time. A load is captured, then written to its slot
//   as its acknowledge beat enters the output register. A match is captured, reads
//   entry 0, then scans: the rule RAM is read once per cycle, one entry per cycle
//   unless a hit waits on the output slot, and each hit is held one step so the last
//   flag is known before the beat leaves. Input reopens once the final beat is registered.
// Reset: positions_in_use = 16, entries_in_use = 0, no beat pending. Rule RAM
//   is not cleared; a slot must be loaded before a scan reaches it.
// Stall: while rsp_stall holds a beat, the scan pauses at the next hit that needs
//   the output slot; nothing is dropped. req_stall is high while an item is busy.
module ternary_rule_match_list_unit #(
    parameter int POSITIONS = trm_pkg::POSITIONS_DEFAULT,
    parameter int ENTRIES   = trm_pkg::ENTRIES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [trm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [trm_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  trm_pkg::req_t                 req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output trm_pkg::rsp_t                 rsp
);

    trm_pkg::cmd_t  cmd;
    trm_pkg::stat_t stat;

    // Sequencer
    trm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Storage, compare and result path
    trm_dp #(
        .POSITIONS (POSITIONS),
        .ENTRIES   (ENTRIES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // Only one item at a time: an accepted beat closes the input next cycle.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("input accepted while an item is busy");

    // Every beat that is not the last one reports a hit.
    a_nonlast_is_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.last |-> rsp.matched)
        else $error("non-final beat without a hit");

    // A hit beat carries a nonzero running count.
    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.matched |-> rsp.match_count != '0)
        else $error("hit beat with zero match count");

    // A hit names a slot inside the table.
    a_hit_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.matched |-> {1'b0, rsp.match_index} < 7'(ENTRIES))
        else $error("hit index beyond table");
`endif

endmodule
